// ===== hdl/signed_128bit_alu_unit_assert.svh =====
// Assertion macros shared by the ALU checker.
// No dependencies.
`ifndef SIGNED_128BIT_ALU_UNIT_ASSERT_SVH
`define SIGNED_128BIT_ALU_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define S128_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define S128_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/s128alu_pkg.sv =====
// Package for the 128-bit signed ALU: opcodes, widths and sequencer states.
// No dependencies.
package s128alu_pkg;
  localparam int unsigned DataW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned ShW   = 7;
  localparam int unsigned CntW  = 7;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_AND  = 4'd4,
    OP_OR   = 4'd5,
    OP_XOR  = 4'd6,
    OP_NOT  = 4'd7,
    OP_SHL  = 4'd8,
    OP_SAR  = 4'd9,
    OP_ROTL = 4'd10,
    OP_ROTR = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SHIFT,
    ST_FIX,
    ST_OUT
  } state_e;
endpackage

// ===== hdl/signed_128bit_alu_unit.sv =====
// 128-bit signed ALU, iterative: one shared 128-bit adder/subtractor, and a one-bit shifter.
// add/sub/logic and divide by zero: ST_FIX, then ST_OUT, which raises out_valid_o.
// mul: 128 steps, then ST_OUT; div: 128 steps plus sign fix in ST_FIX, then ST_OUT.
// shifts/rotates: one bit per cycle in ST_SHIFT, then ST_OUT, which raises out_valid_o.
// One word in flight; in_stall_o stays high from accept until the result is taken.
// rst_ni is asynchronous, active low, and clears the sequencer and the output valid.
// Depends on s128alu_pkg.
module signed_128bit_alu_unit
  import s128alu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        opcode_i,
  input  logic [HalfW-1:0]  a_low_i,
  input  logic [HalfW-1:0]  a_high_i,
  input  logic [HalfW-1:0]  b_low_i,
  input  logic [HalfW-1:0]  b_high_i,
  input  logic [ShW-1:0]    shift_amount_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [HalfW-1:0]  result_low_o,
  output logic [HalfW-1:0]  result_high_o,
  output logic              is_equal_o,
  output logic              is_less_o,
  output logic              is_greater_o,
  output logic              divide_by_zero_o
);

  state_e state_q, state_d;

  // Working registers: acc holds the product / remainder, x the multiplicand /
  // quotient bits / shifted word, y the multiplier / divisor.
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] x_q, x_d;
  logic [DataW-1:0] y_q, y_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [3:0]       op_q, op_d;
  logic             neg_q, neg_d;
  logic             eq_q, eq_d, lt_q, lt_d, gt_q, gt_d, dz_q, dz_d;
  logic             ovld_q, ovld_d;

  // Shared adder: add_a +/- add_b, add_sub selects subtract.
  logic [DataW-1:0] add_a, add_b;
  logic             add_sub;
  logic [DataW:0]   add_s;
  assign add_s = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {{DataW{1'b0}}, add_sub};

  logic [DataW-1:0] a_w, b_w, rem_sh;
  logic             accept;
  assign a_w = {a_high_i, a_low_i};
  assign b_w = {b_high_i, b_low_i};
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign rem_sh = {acc_q[DataW-2:0], x_q[DataW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    cnt_q <= cnt_d;
    op_q  <= op_d;
    neg_q <= neg_d;
    eq_q  <= eq_d;
    lt_q  <= lt_d;
    gt_q  <= gt_d;
    dz_q  <= dz_d;
  end

  always_comb begin
    state_d = state_q;
    ovld_d  = ovld_q;
    acc_d = acc_q; x_d = x_q; y_d = y_q; cnt_d = cnt_q; op_d = op_q;
    neg_d = neg_q; eq_d = eq_q; lt_d = lt_q; gt_d = gt_q; dz_d = dz_q;
    add_a = acc_q; add_b = y_q; add_sub = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = opcode_i;
          eq_d  = (a_w == b_w);
          lt_d  = ($signed(a_w) < $signed(b_w));
          gt_d  = ($signed(a_w) > $signed(b_w));
          dz_d  = 1'b0;
          cnt_d = '0;
          neg_d = 1'b0;
          acc_d = a_w;
          x_d   = a_w;
          y_d   = b_w;
          state_d = ST_FIX;
          case (opcode_i)
            OP_ADD, OP_SUB: state_d = ST_FIX;
            OP_MUL: begin
              acc_d = '0;
              state_d = ST_MUL;
            end
            OP_DIV: begin
              if (b_w == '0) begin
                dz_d = 1'b1;
                acc_d = '0;
                op_d = OP_AND; // zero result via and with zero divisor
              end else begin
                // Magnitudes first; x is the dividend, y the divisor.
                x_d = a_w[DataW-1] ? (~a_w + 1'b1) : a_w;
                y_d = b_w[DataW-1] ? (~b_w + 1'b1) : b_w;
                acc_d = '0;
                neg_d = a_w[DataW-1] ^ b_w[DataW-1];
                state_d = ST_DIV;
              end
            end
            OP_SHL, OP_SAR, OP_ROTL, OP_ROTR: begin
              cnt_d = shift_amount_i;
              state_d = ST_SHIFT;
            end
            default: state_d = ST_FIX;
          endcase
        end
      end
      ST_MUL: begin
        // Shift-add, multiplier bit from the LSB of y, low 128 bits kept.
        add_a = acc_q; add_b = x_q; add_sub = 1'b0;
        if (y_q[0]) acc_d = add_s[DataW-1:0];
        x_d = {x_q[DataW-2:0], 1'b0};
        y_d = {1'b0, y_q[DataW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DataW - 1)) state_d = ST_OUT;
      end
      ST_DIV: begin
        // Restoring step: shift in a dividend bit, subtract divisor if it fits.
        add_a = rem_sh; add_b = y_q; add_sub = 1'b1;
        if (add_s[DataW]) begin
          acc_d = add_s[DataW-1:0];
          x_d = {x_q[DataW-2:0], 1'b1};
        end else begin
          acc_d = rem_sh;
          x_d = {x_q[DataW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DataW - 1)) state_d = ST_FIX;
      end
      ST_SHIFT: begin
        if (cnt_q == '0) begin
          acc_d = x_q;
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
          case (op_q)
            OP_SHL:  x_d = {x_q[DataW-2:0], 1'b0};
            OP_SAR:  x_d = {x_q[DataW-1], x_q[DataW-1:1]};
            OP_ROTL: x_d = {x_q[DataW-2:0], x_q[DataW-1]};
            default: x_d = {x_q[0], x_q[DataW-1:1]};
          endcase
        end
      end
      ST_FIX: begin
        // Finish short ops (add/sub on the shared adder, logic directly); negate quotient if needed.
        state_d = ST_OUT;
        case (op_q)
          OP_ADD: begin
            add_a = acc_q; add_b = y_q; add_sub = 1'b0;
            acc_d = add_s[DataW-1:0];
          end
          OP_SUB: begin
            add_a = acc_q; add_b = y_q; add_sub = 1'b1;
            acc_d = add_s[DataW-1:0];
          end
          OP_DIV: begin
            add_a = '0; add_b = x_q; add_sub = neg_q;
            acc_d = neg_q ? add_s[DataW-1:0] : x_q;
          end
          OP_AND: acc_d = acc_q & y_q;
          OP_OR:  acc_d = acc_q | y_q;
          OP_XOR: acc_d = acc_q ^ y_q;
          OP_NOT: acc_d = ~acc_q;
          default: acc_d = '0;
        endcase
      end
      ST_OUT: begin
        // Hold the result until the downstream side takes it.
        if (!ovld_q) begin
          ovld_d = 1'b1;
        end else if (!out_stall_i) begin
          ovld_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o      = ovld_q;
  assign result_low_o     = acc_q[HalfW-1:0];
  assign result_high_o    = acc_q[DataW-1:HalfW];
  assign is_equal_o       = eq_q;
  assign is_less_o        = lt_q;
  assign is_greater_o     = gt_q;
  assign divide_by_zero_o = dz_q;

endmodule

// ===== hdl/s128alu_checker.sv =====
// Port-level checker for the 128-bit ALU, bound to the top level.
// Depends on signed_128bit_alu_unit_assert.svh.
`include "signed_128bit_alu_unit_assert.svh"
module s128alu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_low_o,
  input logic        is_equal_o,
  input logic        is_less_o,
  input logic        is_greater_o,
  input logic        divide_by_zero_o
);
  logic flags_ok;
  logic shown_stalled;
  assign flags_ok = !(is_less_o && is_greater_o) &&
                    !(is_equal_o && (is_less_o || is_greater_o));
  assign shown_stalled = out_valid_o && out_stall_i;

  // Flags are exclusive while a word is shown.
  `S128_ASSERT_IMP(flags_excl, clk_i, rst_ni, out_valid_o, flags_ok)
  // Busy while a result is shown.
  `S128_ASSERT_IMP(busy_on_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  // Divide by zero gives a zero low result word.
  `S128_ASSERT_IMP(dz_zero, clk_i, rst_ni, out_valid_o && divide_by_zero_o, result_low_o == 64'd0)
  // A stalled result stays.
  `S128_ASSERT_NXT(out_hold, clk_i, rst_ni, shown_stalled, out_valid_o && $stable(result_low_o))
endmodule

bind signed_128bit_alu_unit s128alu_checker u_s128alu_checker (.*);
